@@ rtl/curve25519_field_inverter_core_defines.svh @@
// assertion macros for the field inverter core
`ifndef CURVE25519_FIELD_INVERTER_CORE_DEFINES_SVH
`define CURVE25519_FIELD_INVERTER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define C25INV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define C25INV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/c25inv_pkg.sv @@
// shared types, constants and the addition chain program of the field inverter
`timescale 1ns / 1ps

package c25inv_pkg;

  localparam int unsigned FeW = 255;
  localparam int unsigned NumRegs = 10;
  localparam logic [4:0] LastStep = 5'd21;

  localparam logic [6:0] SqRun5 = 7'd5;
  localparam logic [6:0] SqRun10 = 7'd10;
  localparam logic [6:0] SqRun20 = 7'd20;
  localparam logic [6:0] SqRun50 = 7'd50;
  localparam logic [6:0] SqRun100 = 7'd100;

  typedef enum logic [3:0] {
    R_X, R_Z2, R_Z9, R_Z11, R_Z5, R_Z10, R_Z20, R_Z50, R_Z100, R_T0
  } fe_reg_e;

  // first pass uses a and b, further passes square dst in place
  typedef struct packed {
    fe_reg_e    dst;
    fe_reg_e    a;
    fe_reg_e    b;
    logic [6:0] reps;
  } step_t;

  typedef enum logic [2:0] {
    T_IDLE, T_READ, T_START, T_WAIT, T_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    M_IDLE, M_PROD, M_DRAIN, M_FLUSH, M_FOLD, M_CARRY, M_CANON, M_FINAL, M_DONE
  } mul_state_e;

  function automatic step_t prog_step(input logic [4:0] pc);
    step_t s;
    s = '{dst: R_T0, a: R_T0, b: R_T0, reps: 7'd1};
    unique case (pc)
      5'd0:    s = '{dst: R_Z2,   a: R_X,    b: R_X,    reps: 7'd1};
      5'd1:    s = '{dst: R_T0,   a: R_Z2,   b: R_Z2,   reps: 7'd2};
      5'd2:    s = '{dst: R_Z9,   a: R_T0,   b: R_X,    reps: 7'd1};
      5'd3:    s = '{dst: R_Z11,  a: R_Z9,   b: R_Z2,   reps: 7'd1};
      5'd4:    s = '{dst: R_T0,   a: R_Z11,  b: R_Z11,  reps: 7'd1};
      5'd5:    s = '{dst: R_Z5,   a: R_T0,   b: R_Z9,   reps: 7'd1};
      5'd6:    s = '{dst: R_T0,   a: R_Z5,   b: R_Z5,   reps: SqRun5};
      5'd7:    s = '{dst: R_Z10,  a: R_T0,   b: R_Z5,   reps: 7'd1};
      5'd8:    s = '{dst: R_T0,   a: R_Z10,  b: R_Z10,  reps: SqRun10};
      5'd9:    s = '{dst: R_Z20,  a: R_T0,   b: R_Z10,  reps: 7'd1};
      5'd10:   s = '{dst: R_T0,   a: R_Z20,  b: R_Z20,  reps: SqRun20};
      5'd11:   s = '{dst: R_T0,   a: R_T0,   b: R_Z20,  reps: 7'd1};
      5'd12:   s = '{dst: R_T0,   a: R_T0,   b: R_T0,   reps: SqRun10};
      5'd13:   s = '{dst: R_Z50,  a: R_T0,   b: R_Z10,  reps: 7'd1};
      5'd14:   s = '{dst: R_T0,   a: R_Z50,  b: R_Z50,  reps: SqRun50};
      5'd15:   s = '{dst: R_Z100, a: R_T0,   b: R_Z50,  reps: 7'd1};
      5'd16:   s = '{dst: R_T0,   a: R_Z100, b: R_Z100, reps: SqRun100};
      5'd17:   s = '{dst: R_T0,   a: R_T0,   b: R_Z100, reps: 7'd1};
      5'd18:   s = '{dst: R_T0,   a: R_T0,   b: R_T0,   reps: SqRun50};
      5'd19:   s = '{dst: R_T0,   a: R_T0,   b: R_Z50,  reps: 7'd1};
      5'd20:   s = '{dst: R_T0,   a: R_T0,   b: R_T0,   reps: SqRun5};
      5'd21:   s = '{dst: R_T0,   a: R_T0,   b: R_Z11,  reps: 7'd1};
      default: s = '{dst: R_T0,   a: R_T0,   b: R_T0,   reps: 7'd1};
    endcase
    return s;
  endfunction

endpackage

@@ rtl/curve25519_field_inverter_core.sv @@
// top level of the curve25519 field inverter: chain sequencer and temporaries
//
// usage:
// - input channel: operand_limb0_i..operand_limb3_i with in_valid_i and in_stall_o;
//   a transaction is taken when in_valid_i is high and in_stall_o is low
// - output channel: inverse_limb0_o..inverse_limb3_o with out_valid_o and out_stall_i
// - the operand is reduced mod 2^255-19 on entry, zero gives zero
// - one item at a time: in_stall_o stays high from the accepted transaction until
//   the result has been taken
// - each of the 265 chain steps runs on one shared modular multiplier that does
//   64 32x32 partial products and then reduces the product mod p; each step first
//   fetches its operands from the temporaries
// - while out_stall_i is high the result is held stable and nothing new is taken
// - reset returns the sequencer to idle and drops out_valid_o; the temporaries
//   hold no meaning until written by the next item
`timescale 1ns / 1ps
`include "curve25519_field_inverter_core_defines.svh"

module curve25519_field_inverter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] operand_limb0_i,
  input  logic [63:0] operand_limb1_i,
  input  logic [63:0] operand_limb2_i,
  input  logic [62:0] operand_limb3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] inverse_limb0_o,
  output logic [63:0] inverse_limb1_o,
  output logic [63:0] inverse_limb2_o,
  output logic [62:0] inverse_limb3_o
);

  c25inv_pkg::top_state_e state_q, state_d;

  logic [4:0] pc_q;
  logic [6:0] iter_q;

  logic [c25inv_pkg::FeW-1:0] mem_q [c25inv_pkg::NumRegs];
  logic [c25inv_pkg::FeW-1:0] opa_q, opb_q;

  c25inv_pkg::step_t   step;
  c25inv_pkg::fe_reg_e rd_a, rd_b, wr_addr;
  logic                accept, first_pass, last_iter, wr_en;
  logic                mul_start, mul_done;
  logic [254:0]        x_raw, mul_res, wr_data;
  logic [255:0]        x_plus;

  assign accept     = in_valid_i && !in_stall_o;
  assign step       = c25inv_pkg::prog_step(pc_q);
  assign first_pass = (iter_q == 7'd0);
  assign last_iter  = (iter_q == step.reps - 7'd1);
  assign rd_a       = first_pass ? step.a : step.dst;
  assign rd_b       = first_pass ? step.b : step.dst;

  // x >= p exactly when x + 19 reaches bit 255
  assign x_raw  = {operand_limb3_i, operand_limb2_i, operand_limb1_i, operand_limb0_i};
  assign x_plus = {1'b0, x_raw} + 256'd19;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = c25inv_pkg::R_X;
    wr_data = x_plus[255] ? x_plus[254:0] : x_raw;
    if (accept) begin
      wr_en = 1'b1;
    end else if (state_q == c25inv_pkg::T_WAIT && mul_done) begin
      wr_en   = 1'b1;
      wr_addr = step.dst;
      wr_data = mul_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (state_q == c25inv_pkg::T_READ) begin
      opa_q <= mem_q[rd_a];
      opb_q <= mem_q[rd_b];
    end
  end

  c25inv_fmul u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c25inv_pkg::T_IDLE:  if (accept) state_d = c25inv_pkg::T_READ;
      c25inv_pkg::T_READ:  state_d = c25inv_pkg::T_START;
      c25inv_pkg::T_START: state_d = c25inv_pkg::T_WAIT;
      c25inv_pkg::T_WAIT: begin
        if (mul_done) begin
          if (last_iter && pc_q == c25inv_pkg::LastStep) state_d = c25inv_pkg::T_OUT;
          else state_d = c25inv_pkg::T_READ;
        end
      end
      c25inv_pkg::T_OUT:   if (!out_stall_i) state_d = c25inv_pkg::T_IDLE;
      default:             state_d = c25inv_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != c25inv_pkg::T_IDLE);
    out_valid_o     = (state_q == c25inv_pkg::T_OUT);
    mul_start       = (state_q == c25inv_pkg::T_START);
    inverse_limb0_o = mul_res[63:0];
    inverse_limb1_o = mul_res[127:64];
    inverse_limb2_o = mul_res[191:128];
    inverse_limb3_o = mul_res[254:192];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c25inv_pkg::T_IDLE;
      pc_q    <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pc_q   <= '0;
        iter_q <= '0;
      end else if (state_q == c25inv_pkg::T_WAIT && mul_done) begin
        if (!last_iter) begin
          iter_q <= iter_q + 7'd1;
        end else if (pc_q != c25inv_pkg::LastStep) begin
          pc_q   <= pc_q + 5'd1;
          iter_q <= '0;
        end
      end
    end
  end

  `C25INV_ASSERT_SAME(a_out_blocks_in, out_valid_o, in_stall_o, "input taken while result waits")
  `C25INV_ASSERT_SAME(a_done_in_wait, mul_done, state_q == c25inv_pkg::T_WAIT, "stray mul done")
  `C25INV_ASSERT_NEXT(a_accept_reads, accept, state_q == c25inv_pkg::T_READ, "accept lost")

endmodule

@@ rtl/c25inv_fmul.sv @@
// modular multiplier mod 2^255-19 built on one 32x32 multiplier
`timescale 1ns / 1ps

module c25inv_fmul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [254:0] a_i,
  input  logic [254:0] b_i,
  output logic         done_o,
  output logic [254:0] res_o
);

  c25inv_pkg::mul_state_e state_q, state_d;

  logic [3:0]   k_q;
  logic [2:0]   i_q;
  logic [2:0]   cnt_q;
  logic         pvld_q;
  logic         plast_q;
  logic [63:0]  prod_q;
  logic [67:0]  acc_q;
  logic [511:0] t_q;
  logic [39:0]  c_q;
  logic [255:0] w_q;
  logic [254:0] res_q;

  logic [255:0] a_ext, b_ext;
  logic [3:0]   j_full, k_next;
  logic [2:0]   i_max, i_min_next;
  logic [31:0]  a_word, b_word;
  logic         last_pair, prod_done;
  logic [67:0]  sum;
  logic [39:0]  fsum;
  logic [256:0] csum;
  logic [255:0] fin_sum;

  assign a_ext      = {1'b0, a_i};
  assign b_ext      = {1'b0, b_i};
  assign j_full     = k_q - {1'b0, i_q};
  assign a_word     = a_ext[i_q*32 +: 32];
  assign b_word     = b_ext[j_full[2:0]*32 +: 32];
  assign i_max      = (k_q > 4'd7) ? 3'd7 : k_q[2:0];
  assign k_next     = k_q + 4'd1;
  assign i_min_next = (k_next > 4'd7) ? 3'(k_next - 4'd7) : 3'd0;
  assign last_pair  = (i_q == i_max);
  assign prod_done  = last_pair && (k_q == 4'd14);
  assign sum        = acc_q + {4'b0, prod_q};
  assign fsum       = c_q + {8'b0, t_q[31:0]} + {2'b0, {6'b0, t_q[287:256]} * 38'd38};
  assign csum       = {1'b0, w_q} + {211'b0, {6'b0, c_q} * 46'd38};
  assign fin_sum    = w_q + 256'd19;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c25inv_pkg::M_IDLE:  if (start_i) state_d = c25inv_pkg::M_PROD;
      c25inv_pkg::M_PROD:  if (prod_done) state_d = c25inv_pkg::M_DRAIN;
      c25inv_pkg::M_DRAIN: state_d = c25inv_pkg::M_FLUSH;
      c25inv_pkg::M_FLUSH: state_d = c25inv_pkg::M_FOLD;
      c25inv_pkg::M_FOLD:  if (cnt_q == 3'd7) state_d = c25inv_pkg::M_CARRY;
      c25inv_pkg::M_CARRY: if (cnt_q == 3'd1) state_d = c25inv_pkg::M_CANON;
      c25inv_pkg::M_CANON: if (cnt_q == 3'd1) state_d = c25inv_pkg::M_FINAL;
      c25inv_pkg::M_FINAL: state_d = c25inv_pkg::M_DONE;
      c25inv_pkg::M_DONE:  state_d = c25inv_pkg::M_IDLE;
      default:             state_d = c25inv_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == c25inv_pkg::M_DONE);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c25inv_pkg::M_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      pvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pvld_q  <= (state_q == c25inv_pkg::M_PROD);
      unique case (state_q) inside
        c25inv_pkg::M_IDLE: begin
          k_q <= '0;
          i_q <= '0;
        end
        c25inv_pkg::M_PROD: begin
          if (last_pair) begin
            k_q <= k_next;
            i_q <= i_min_next;
          end else begin
            i_q <= i_q + 3'd1;
          end
        end
        c25inv_pkg::M_FLUSH: cnt_q <= '0;
        c25inv_pkg::M_FOLD:  cnt_q <= cnt_q + 3'd1;
        c25inv_pkg::M_CARRY, c25inv_pkg::M_CANON: begin
          cnt_q <= (cnt_q == 3'd1) ? 3'd0 : cnt_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    // column accumulate, one word of the product leaves at each column end
    if (pvld_q) begin
      if (plast_q) begin
        t_q   <= {sum[31:0], t_q[511:32]};
        acc_q <= {32'b0, sum[67:32]};
      end else begin
        acc_q <= sum;
      end
    end
    unique case (state_q)
      c25inv_pkg::M_IDLE: begin
        if (start_i) acc_q <= '0;
      end
      c25inv_pkg::M_PROD: begin
        prod_q  <= a_word * b_word;
        plast_q <= last_pair;
      end
      c25inv_pkg::M_FLUSH: begin
        t_q <= {acc_q[31:0], t_q[511:32]};
        c_q <= '0;
      end
      c25inv_pkg::M_FOLD: begin
        // 2^256 = 38 mod p
        w_q <= {fsum[31:0], w_q[255:32]};
        c_q <= {32'b0, fsum[39:32]};
        t_q <= {32'b0, t_q[511:32]};
      end
      c25inv_pkg::M_CARRY: begin
        w_q <= csum[255:0];
        c_q <= {39'b0, csum[256]};
      end
      c25inv_pkg::M_CANON: begin
        w_q <= {1'b0, w_q[254:0]} + (w_q[255] ? 256'd19 : 256'd0);
      end
      c25inv_pkg::M_FINAL: begin
        res_q <= fin_sum[255] ? fin_sum[254:0] : w_q[254:0];
      end
      default: ;
    endcase
  end

endmodule

@@ sim/tb_curve25519_field_inverter_core.sv @@
// testbench for the curve25519 field inverter core: operands checked against x^(p-2) mod p
`timescale 1ns / 1ps

module tb_curve25519_field_inverter_core;

  localparam bit [254:0] PrimeP = {1'b0, 254'd0} - 255'd19;
  localparam int unsigned StallLimit = 200000;

  typedef struct {
    bit [63:0] limb0;
    bit [63:0] limb1;
    bit [63:0] limb2;
    bit [62:0] limb3;
  } inverse_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] operand_limb0_i = '0;
  logic [63:0] operand_limb1_i = '0;
  logic [63:0] operand_limb2_i = '0;
  logic [62:0] operand_limb3_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] inverse_limb0_o;
  logic [63:0] inverse_limb1_o;
  logic [63:0] inverse_limb2_o;
  logic [62:0] inverse_limb3_o;

  inverse_t    pending_inverses[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  curve25519_field_inverter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operand_limb0_i(operand_limb0_i),
    .operand_limb1_i(operand_limb1_i),
    .operand_limb2_i(operand_limb2_i),
    .operand_limb3_i(operand_limb3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inverse_limb0_o(inverse_limb0_o),
    .inverse_limb1_o(inverse_limb1_o),
    .inverse_limb2_o(inverse_limb2_o),
    .inverse_limb3_o(inverse_limb3_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit [254:0] field_mul(bit [254:0] a, bit [254:0] b);
    bit [511:0] wide;
    wide = {257'd0, a} * {257'd0, b};
    wide = wide % {257'd0, PrimeP};
    return wide[254:0];
  endfunction

  // fermat inverse: x^(p-2), zero maps to zero
  function automatic inverse_t field_inverse(bit [254:0] x);
    bit [254:0] expo;
    bit [254:0] acc;
    bit [254:0] base;
    inverse_t   r;
    expo = PrimeP - 255'd2;
    base = (x >= PrimeP) ? x - PrimeP : x;
    acc = 255'd1;
    for (int i = 254; i >= 0; i--) begin
      acc = field_mul(acc, acc);
      if (expo[i]) acc = field_mul(acc, base);
    end
    r.limb0 = acc[63:0];
    r.limb1 = acc[127:64];
    r.limb2 = acc[191:128];
    r.limb3 = acc[254:192];
    return r;
  endfunction

  task automatic send_operand(bit [254:0] x);
    if (!steady && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operand_limb0_i <= x[63:0];
    operand_limb1_i <= x[127:64];
    operand_limb2_i <= x[191:128];
    operand_limb3_i <= x[254:192];
    do @(posedge clk_i); while (in_stall_o);
    pending_inverses.push_back(field_inverse(x));
  endtask

  function automatic bit [254:0] random_operand();
    bit [254:0] x;
    x = 255'({$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(7))
      0: x = x >> $urandom_range(200, 254);
      1: x = PrimeP + (x & 255'd31);
      2: x = PrimeP - 255'd1 - (x & 255'hff);
      default: ;
    endcase
    return x;
  endfunction

  task automatic test_edge_operands();
    bit [254:0] edges[$];
    edges = '{255'd0, 255'd1, 255'd2, 255'd9, PrimeP - 255'd1, PrimeP, PrimeP + 255'd1,
              PrimeP + 255'd18, ~255'd0, {191'd0, 64'hffff_ffff_ffff_ffff},
              {127'd0, 64'hffff_ffff_ffff_ffff, 64'd0},
              {63'd0, 64'hffff_ffff_ffff_ffff, 128'd0},
              {63'h7fff_ffff_ffff_ffff, 192'd0}, {1'b1, 254'd0},
              255'({128{2'b01}} >> 1), 255'({128{2'b10}} >> 1)};
    foreach (edges[i]) send_operand(edges[i]);
  endtask

  task automatic test_random_steady(int unsigned count);
    steady = 1'b1;
    repeat (count) send_operand(random_operand());
    steady = 1'b0;
  endtask

  task automatic test_random_idling(int unsigned count);
    repeat (count) send_operand(random_operand());
  endtask

  // sender holds off until the result queue has drained
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    send_operand(random_operand());
  endtask

  always @(posedge clk_i) begin
    if (steady) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 14);
  end

  always @(posedge clk_i) begin
    inverse_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_inverses.size() == 0) begin
        $error("unexpected transaction on output");
        error_count++;
      end else begin
        want = pending_inverses.pop_front();
        if (inverse_limb0_o !== want.limb0) begin
          $error("inverse_limb0 expected %h actual %h", want.limb0, inverse_limb0_o);
          error_count++;
        end
        if (inverse_limb1_o !== want.limb1) begin
          $error("inverse_limb1 expected %h actual %h", want.limb1, inverse_limb1_o);
          error_count++;
        end
        if (inverse_limb2_o !== want.limb2) begin
          $error("inverse_limb2 expected %h actual %h", want.limb2, inverse_limb2_o);
          error_count++;
        end
        if (inverse_limb3_o !== want.limb3) begin
          $error("inverse_limb3 expected %h actual %h", want.limb3, inverse_limb3_o);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_operands();
    test_random_steady(60);
    test_drain_pause();
    test_random_idling(224);
    in_valid_i <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
